[rtl/core/tjpq_pkg.sv]
// Shared types and codes for the timed job priority queue.
// Holds operation and status codes, controller states and the control structs.
// No dependencies.
package tjpq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT      = 2'd0,
      OP_POP         = 2'd1,
      OP_CANCEL_ID   = 2'd2,
      OP_CANCEL_KIND = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // latch request, reset pass counters
      logic scan;      // stream stored entries through the compaction pass
      logic finish;    // write the trailing entry, settle count and status
      logic load_rsp;  // move the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done; // every entry read and processed
   } stat_type;

endpackage

[rtl/core/timed_job_priority_queue.sv]
// Top level of the timed job priority queue.
// Joins the controller (tjpq_ctrl) and the datapath (tjpq_datapath); uses tjpq_pkg.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | operation, job_id, job_kind, start_time
//   rsp_    | out       | rsp_valid/rsp_stall  | status, popped_*, next_time,
//           |           |                      | queue_size, removed_count
//
// Each request runs a compaction pass, which streams every stored entry once through
// the single read port of the entry memory and writes the survivors back in place;
// an insert dropped by a full queue skips the pass. The next request is accepted
// only once the result has moved into the output register.
// Reset clears the job count, the controller state and the result valid; the entry
// memory is not cleared.
// A finished result waits in the output register under rsp_stall while the next
// request is accepted and worked; that request's result holds until the slot frees.
module timed_job_priority_queue #(
   parameter int DEPTH     = 16,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_job_id,
   input  logic [7:0]  req_job_kind,
   input  logic [31:0] req_start_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_popped_id,
   output logic [7:0]  rsp_popped_kind,
   output logic [31:0] rsp_popped_time,
   output logic [31:0] rsp_next_time,
   output logic [4:0]  rsp_queue_size,
   output logic [4:0]  rsp_removed_count
);

   tjpq_pkg::cmd_type  cmd;
   tjpq_pkg::stat_type stat;

   // Sequence each request: accept, scan pass, finish, hand off the result.
   tjpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the sorted jobs, compact or extend them, and register the result.
   tjpq_datapath #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_job_id        (req_job_id),
      .req_job_kind      (req_job_kind),
      .req_start_time    (req_start_time),
      .rsp_status        (rsp_status),
      .rsp_popped_id     (rsp_popped_id),
      .rsp_popped_kind   (rsp_popped_kind),
      .rsp_popped_time   (rsp_popped_time),
      .rsp_next_time     (rsp_next_time),
      .rsp_queue_size    (rsp_queue_size),
      .rsp_removed_count (rsp_removed_count)
   );

endmodule

[rtl/core/tjpq_ctrl.sv]
// Controller state machine for the timed job priority queue.
// Sequences accept, scan pass, finish and result hand-off.
// Depends on tjpq_pkg.
module tjpq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tjpq_pkg::stat_type  stat,
   output tjpq_pkg::cmd_type   cmd
);

   tjpq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tjpq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tjpq_pkg::S_IDLE: begin
            if (req_valid) state_in = tjpq_pkg::S_SCAN;
         end
         tjpq_pkg::S_SCAN: begin
            if (stat.scan_done) state_in = tjpq_pkg::S_FINISH;
         end
         tjpq_pkg::S_FINISH: begin
            state_in = tjpq_pkg::S_RESULT;
         end
         tjpq_pkg::S_RESULT: begin
            if (slot_free) state_in = tjpq_pkg::S_IDLE;
         end
         default: state_in = tjpq_pkg::S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         tjpq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         tjpq_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
         end
         tjpq_pkg::S_FINISH: begin
            cmd.finish = 1'b1;
         end
         tjpq_pkg::S_RESULT: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/tjpq_datapath.sv]
// Datapath for the timed job priority queue: sorted entry memory,
// in-place compaction pass, request latch and result register.
// Depends on tjpq_pkg.
module tjpq_datapath #(
   parameter int DEPTH     = 16,
   parameter int TIME_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  tjpq_pkg::cmd_type  cmd,
   output tjpq_pkg::stat_type stat,
   input  logic [1:0]         req_operation,
   input  logic [15:0]        req_job_id,
   input  logic [7:0]         req_job_kind,
   input  logic [31:0]        req_start_time,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_popped_id,
   output logic [7:0]         rsp_popped_kind,
   output logic [31:0]        rsp_popped_time,
   output logic [31:0]        rsp_next_time,
   output logic [4:0]         rsp_queue_size,
   output logic [4:0]         rsp_removed_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [TIME_BITS-1:0] start_tick;
      logic [15:0]          job_id;
      logic [7:0]           job_kind;
   } entry_type;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   tjpq_pkg::op_type op_ff, op_in;
   entry_type        req_ff, req_in;
   entry_type        carry_ff, carry_in;
   entry_type        popped_ff, popped_in;
   logic [CW-1:0]    held_ff, held_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CW-1:0]    wr_idx_ff, wr_idx_in;
   logic [CW-1:0]    removed_ff, removed_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             flag_ff, flag_in;
   logic             drop_ff, drop_in;
   logic [TIME_BITS-1:0] head_ff, head_in;
   tjpq_pkg::status_type status_ff, status_in;

   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_popped_id_ff;
   logic [7:0]  rsp_popped_kind_ff;
   logic [31:0] rsp_popped_time_ff;
   logic [31:0] rsp_next_time_ff;
   logic [4:0]  rsp_queue_size_ff;
   logic [4:0]  rsp_removed_count_ff;

   logic [CW-1:0] limit;
   logic          issue;
   logic          rd_en;
   logic          mem_we;
   entry_type     mem_wdata;
   logic [CW-1:0] wr_final;
   logic [63:0]   req_time_wide;
   logic [63:0]   head_wide;
   logic [63:0]   popped_wide;
   logic [15:0]   held_wide;
   logic [15:0]   removed_wide;

   assign req_time_wide = 64'(req_start_time);
   assign limit         = drop_ff ? '0 : held_ff;
   assign issue         = rd_idx_ff < limit;
   assign stat.scan_done = !issue && !rd_pend_ff;
   assign wr_final      = (op_ff == tjpq_pkg::OP_INSERT) ? wr_idx_ff + CW'(1) : wr_idx_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_idx_ff[IW-1:0]];
      if (mem_we) mem[wr_idx_ff[IW-1:0]] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         held_ff    <= held_in;
         rd_pend_ff <= rd_pend_in;
      end
      op_ff      <= op_in;
      req_ff     <= req_in;
      carry_ff   <= carry_in;
      popped_ff  <= popped_in;
      rd_idx_ff  <= rd_idx_in;
      wr_idx_ff  <= wr_idx_in;
      removed_ff <= removed_in;
      flag_ff    <= flag_in;
      drop_ff    <= drop_in;
      head_ff    <= head_in;
      status_ff  <= status_in;
   end

   always_comb begin
      op_in      = op_ff;
      req_in     = req_ff;
      carry_in   = carry_ff;
      popped_in  = popped_ff;
      held_in    = held_ff;
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = wr_idx_ff;
      removed_in = removed_ff;
      rd_pend_in = 1'b0;
      flag_in    = flag_ff;
      drop_in    = drop_ff;
      head_in    = head_ff;
      status_in  = status_ff;
      rd_en      = 1'b0;
      mem_we     = 1'b0;
      mem_wdata  = rd_data_ff;

      if (cmd.start) begin
         op_in             = tjpq_pkg::op_type'(req_operation);
         req_in.start_tick = req_time_wide[TIME_BITS-1:0];
         req_in.job_id     = req_job_id;
         req_in.job_kind   = req_job_kind;
         rd_idx_in         = '0;
         wr_idx_in         = '0;
         flag_in           = 1'b0;
         drop_in           = (tjpq_pkg::op_type'(req_operation) == tjpq_pkg::OP_INSERT)
                             && (held_ff == CW'(DEPTH));
      end

      if (cmd.scan) begin
         // Issue the next read while the previous entry is processed.
         rd_en      = issue;
         rd_pend_in = issue;
         if (issue) rd_idx_in = rd_idx_ff + CW'(1);

         if (rd_pend_ff) begin
            mem_we = 1'b1;
            case (op_ff)
               tjpq_pkg::OP_INSERT: begin
                  carry_in = rd_data_ff;
                  if (!flag_ff && (req_ff.start_tick < rd_data_ff.start_tick)) begin
                     mem_wdata = req_ff;
                     flag_in   = 1'b1;
                  end else if (flag_ff) begin
                     mem_wdata = carry_ff;
                  end
               end
               tjpq_pkg::OP_POP: begin
                  if (!flag_ff) begin
                     popped_in = rd_data_ff;
                     flag_in   = 1'b1;
                     mem_we    = 1'b0;
                  end
               end
               tjpq_pkg::OP_CANCEL_ID: begin
                  if (!flag_ff && (rd_data_ff.job_id == req_ff.job_id)) begin
                     flag_in = 1'b1;
                     mem_we  = 1'b0;
                  end
               end
               tjpq_pkg::OP_CANCEL_KIND: begin
                  if (rd_data_ff.job_kind == req_ff.job_kind) mem_we = 1'b0;
               end
               default: mem_we = 1'b0;
            endcase
         end
      end

      if (cmd.finish) begin
         // Append the trailing entry of an insert: the new job or the carry.
         if ((op_ff == tjpq_pkg::OP_INSERT) && !drop_ff) begin
            mem_we    = 1'b1;
            mem_wdata = flag_ff ? carry_ff : req_ff;
         end
         if (!drop_ff) held_in = wr_final;
         removed_in = (op_ff == tjpq_pkg::OP_INSERT) ? '0 : held_ff - wr_final;
         case (op_ff)
            tjpq_pkg::OP_INSERT:    status_in = drop_ff ? tjpq_pkg::ST_FULL : tjpq_pkg::ST_OK;
            tjpq_pkg::OP_POP:       status_in = (held_ff == '0) ? tjpq_pkg::ST_EMPTY
                                                                : tjpq_pkg::ST_OK;
            tjpq_pkg::OP_CANCEL_ID: status_in = flag_ff ? tjpq_pkg::ST_OK
                                                        : tjpq_pkg::ST_NOT_FOUND;
            default:                status_in = tjpq_pkg::ST_OK;
         endcase
      end

      // Track the head time as the entry written at position zero.
      if (mem_we) begin
         wr_idx_in = wr_idx_ff + CW'(1);
         if (wr_idx_ff == '0) head_in = mem_wdata.start_tick;
      end
   end

   assign head_wide    = 64'(head_ff);
   assign popped_wide  = 64'(popped_ff.start_tick);
   assign held_wide    = 16'(held_ff);
   assign removed_wide = 16'(removed_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff        <= status_ff;
         rsp_next_time_ff     <= (held_ff != '0) ? head_wide[31:0] : 32'd0;
         rsp_queue_size_ff    <= held_wide[4:0];
         rsp_removed_count_ff <= removed_wide[4:0];
         if ((op_ff == tjpq_pkg::OP_POP) && flag_ff) begin
            rsp_popped_id_ff   <= popped_ff.job_id;
            rsp_popped_kind_ff <= popped_ff.job_kind;
            rsp_popped_time_ff <= popped_wide[31:0];
         end else begin
            rsp_popped_id_ff   <= '0;
            rsp_popped_kind_ff <= '0;
            rsp_popped_time_ff <= '0;
         end
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_popped_id     = rsp_popped_id_ff;
   assign rsp_popped_kind   = rsp_popped_kind_ff;
   assign rsp_popped_time   = rsp_popped_time_ff;
   assign rsp_next_time     = rsp_next_time_ff;
   assign rsp_queue_size    = rsp_queue_size_ff;
   assign rsp_removed_count = rsp_removed_count_ff;

endmodule
